// ===== rtl/core/avs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_pkg
// Types shared by the ascending value sorter and its users.
// ----------------------------------------------------------------------------
package avs_pkg;

   localparam int VALUE_W = 32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      end_of_run;
      logic                      overflow;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_CMP     = 5'b00010,
      ST_WRV     = 5'b00100,
      ST_EMIT_RD = 5'b01000,
      ST_EMIT    = 5'b10000
   } state_type;

endpackage

// ===== rtl/core/ascending_value_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_value_sorter
// Insertion sort of one set of signed values held in a single-port-write,
// registered-read memory.
// ----------------------------------------------------------------------------
// The sorter takes one signed value per request and keeps up to DEPTH of them
// in ascending order in an internal memory. A request whose last bit is set
// ends the set; the sorter then returns every stored value in ascending order,
// one response each, with end_of_run set on the greatest one and overflow set
// on all of them if any value of the set was dropped for lack of room. A
// request that finds the store empty or full is done in ST_IDLE. Any other
// request walks down the memory from the top entry in ST_CMP, shifting up
// every stored value greater than the new one, and writes the new value in
// the slot it frees, in ST_CMP or ST_WRV; the read-compare-write walk covers
// one entry per cycle. The block works on one request at a time and accepts
// no request while a run is being emitted. Each response of a run is read
// from the memory in ST_EMIT_RD and then offered in ST_EMIT until taken.
// ----------------------------------------------------------------------------
module ascending_value_sorter
   import avs_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Control state.
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                drop_ff, drop_in;

   // Working registers for the insertion walk and the emit pass.
   logic [ADDR_W-1:0]         pos_ff, pos_in;
   logic [ADDR_W-1:0]         idx_ff, idx_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                      last_ff, last_in;

   // The value store and its ports.
   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_wa;
   logic signed [VALUE_W-1:0] mem_wd;
   logic                      mem_re;
   logic [ADDR_W-1:0]         mem_ra;

   logic                      run_end;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   // The final response of a run is the one at the highest stored index.
   assign run_end = (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      drop_in   = drop_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      last_in   = last_ff;
      mem_we    = 1'b0;
      mem_wa    = pos_ff;
      mem_wd    = val_ff;
      mem_re    = 1'b0;
      mem_ra    = idx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               val_in  = req_data.value;
               last_in = req_data.last;
               idx_in  = '0;
               if (count_ff == CNT_W'(DEPTH)) begin
                  // The store is full: the value is dropped, but a last
                  // request still ends the set.
                  drop_in = 1'b1;
                  if (req_data.last) begin
                     state_in = ST_EMIT_RD;
                  end
               end else if (count_ff == '0) begin
                  // An empty store takes the value at the bottom directly.
                  mem_we   = 1'b1;
                  mem_wa   = '0;
                  mem_wd   = req_data.value;
                  count_in = CNT_W'(1);
                  if (req_data.last) begin
                     state_in = ST_EMIT_RD;
                  end
               end else begin
                  // Start the walk at the free slot above the top entry.
                  pos_in   = count_ff[ADDR_W-1:0];
                  mem_re   = 1'b1;
                  mem_ra   = count_ff[ADDR_W-1:0] - ADDR_W'(1);
                  count_in = count_ff + CNT_W'(1);
                  state_in = ST_CMP;
               end
            end
         end

         ST_CMP: begin
            // rd_data_ff holds the entry just below pos_ff.
            mem_we = 1'b1;
            mem_wa = pos_ff;
            if (rd_data_ff > val_ff) begin
               mem_wd = rd_data_ff;
               pos_in = pos_ff - ADDR_W'(1);
               if (pos_ff == ADDR_W'(1)) begin
                  state_in = ST_WRV;
               end else begin
                  mem_re = 1'b1;
                  mem_ra = pos_ff - ADDR_W'(2);
               end
            end else begin
               mem_wd   = val_ff;
               state_in = last_ff ? ST_EMIT_RD : ST_IDLE;
            end
         end

         ST_WRV: begin
            mem_we   = 1'b1;
            mem_wa   = pos_ff;
            mem_wd   = val_ff;
            state_in = last_ff ? ST_EMIT_RD : ST_IDLE;
         end

         ST_EMIT_RD: begin
            mem_re   = 1'b1;
            mem_ra   = idx_ff;
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (run_end) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      last_ff <= last_in;
   end

   // The read register holds still while a response is offered.
   assign rsp_data.sorted_value = rd_data_ff;
   assign rsp_data.end_of_run   = run_end;
   assign rsp_data.overflow     = drop_ff;

endmodule

// ===== dv/tb_ascending_value_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascending_value_sorter
// Self-checking testbench for the ascending value sorter.
// ----------------------------------------------------------------------------
// Sets of signed values are sent as requests, each set ended by a request
// with last set. A behavioral sorting model predicts every response of each
// run from the accepted requests. A checker compares every accepted response
// field by field with the oldest prediction. The stimulus starts with
// directed sets: the extreme values, equal values and a one-value set.
// Random sets follow under several patterns of sender idling and receiver
// stalling; among them come a completely full store and a store that
// overflows, including a dropped final value.
// ----------------------------------------------------------------------------
module tb_ascending_value_sorter;
   import avs_pkg::*;

   localparam int SORT_DEPTH = 64;
   localparam int CLK_HALF   = 10;
   // A request walks at most the whole store, and each response is read
   // from memory before it is offered, so this covers any work still under
   // way after the last expected response has arrived.
   localparam int SETTLE_CYCLES = 2 * SORT_DEPTH + 16;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Idle and stall chances, in percent, for the phase that is running.
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned error_count = 0;

   // Sorting model: the values held so far, in ascending order, and
   // whether this set has lost a value for lack of room.
   logic signed [VALUE_W-1:0] model_values[$];
   logic                      model_dropped;

   // Responses predicted but not yet seen at the output, oldest first.
   rsp_type predicted_rsps[$];

   ascending_value_sorter #(
      .DEPTH(SORT_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Safety net in case the sorter hangs.
   initial begin
      #10ms;
      $display("Test completed with failures");
      $finish;
   end

   // The receiver decides afresh on every cycle whether to take a response.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Every accepted response must match the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_rsps.size() == 0) begin
            $display("%0t: unexpected response value=%0d end_of_run=%0b overflow=%0b",
                     $time, rsp_data.sorted_value, rsp_data.end_of_run,
                     rsp_data.overflow);
            error_count++;
         end else begin
            want = predicted_rsps.pop_front();
            if (rsp_data.sorted_value !== want.sorted_value) begin
               $display("%0t: sorted_value expected %0d actual %0d",
                        $time, want.sorted_value, rsp_data.sorted_value);
               error_count++;
            end
            if (rsp_data.end_of_run !== want.end_of_run) begin
               $display("%0t: end_of_run expected %0b actual %0b",
                        $time, want.end_of_run, rsp_data.end_of_run);
               error_count++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $display("%0t: overflow expected %0b actual %0b",
                        $time, want.overflow, rsp_data.overflow);
               error_count++;
            end
         end
      end
   end

   // Takes one accepted request into the model. A new value goes after any
   // equal values already held, and a value that finds the store full is
   // dropped. A request with last set releases the whole run, even when its
   // own value was dropped.
   task automatic model_accept(input req_type item);
      int      pos;
      rsp_type rsp;
      if (model_values.size() >= SORT_DEPTH) begin
         model_dropped = 1'b1;
      end else begin
         pos = model_values.size();
         while (pos > 0 && model_values[pos-1] > item.value) pos--;
         model_values.insert(pos, item.value);
      end
      if (item.last) begin
         foreach (model_values[k]) begin
            rsp.sorted_value = model_values[k];
            rsp.end_of_run   = (k == model_values.size() - 1);
            rsp.overflow     = model_dropped;
            predicted_rsps.insert(predicted_rsps.size(), rsp);
         end
         model_values.delete();
         model_dropped = 1'b0;
      end
   endtask

   // Offers one request, after a random number of idle cycles, and returns
   // at the clock edge where it is accepted. Valid stays high across
   // back-to-back requests.
   task automatic send_value(input logic signed [VALUE_W-1:0] value, input logic last);
      req_type item;
      item.value = value;
      item.last  = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      model_accept(item);
   endtask

   // Holds the sender off until every predicted response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (predicted_rsps.size() != 0) @(posedge clock);
   endtask

   // Mostly plain random values, with the extremes and a narrow band
   // around zero mixed in so that equal values turn up often.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3:    return $signed($urandom_range(8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   // Extreme values, alternating bit patterns and repeated values, sent
   // back to back, then a set of a single value.
   task automatic test_directed_extremes();
      logic signed [VALUE_W-1:0] values[$];
      values = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh5555_5555,
                 32'shAAAA_AAAA, 7, 7, -7, 32'sh8000_0000};
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (values[k]) send_value(values[k], k == values.size() - 1);
      send_value(32'sh8000_0000, 1'b1);
      wait_drained();
   endtask

   // A set that exactly fills the store must not report overflow. The next
   // set has two values too many, so the final value is dropped yet still
   // ends the set. A short set afterward shows that overflow was cleared.
   task automatic test_full_store();
      for (int k = 0; k < SORT_DEPTH; k++) send_value(pick_value(), k == SORT_DEPTH - 1);
      wait_drained();
      for (int k = 0; k < SORT_DEPTH + 2; k++) send_value(pick_value(), k == SORT_DEPTH + 1);
      wait_drained();
      send_value(pick_value(), 1'b0);
      send_value(pick_value(), 1'b1);
      wait_drained();
   endtask

   // Random sets of mostly small sizes under one pattern of idling and
   // stalling. Each set is always closed with a last request so that the
   // store starts empty in the next phase.
   task automatic test_random_sets(input int unsigned idle_pct,
                                   input int unsigned stall_pct,
                                   input int          num_items);
      int sent;
      int set_len;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < num_items) begin
         set_len = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
         for (int k = 0; k < set_len; k++) send_value(pick_value(), k == set_len - 1);
         sent += set_len;
      end
      wait_drained();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      model_dropped  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_random_sets(0, 0, 60);
      test_random_sets(74, 0, 60);
      test_random_sets(0, 74, 60);
      send_idle_pct  = 25;
      recv_stall_pct = 25;
      test_full_store();
      test_random_sets(25, 25, 60);

      // Any response beyond the predicted ones shows up in this window.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/avs_pkg.sv
rtl/core/ascending_value_sorter.sv
dv/tb_ascending_value_sorter.sv
